// ===== rtl/psad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psad_pkg: shared types and constants of the program stream audio demux
// Result kinds, register indexes, reset values and the event that travels
// from the parser to the output stage.
// ----------------------------------------------------------------------------
package psad_pkg;

  // Result kinds carried on the output tuser.
  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_END     = 3'd1;
  localparam logic [2:0] KIND_NOT_PS  = 3'd2;
  localparam logic [2:0] KIND_SYNC    = 3'd3;
  localparam logic [2:0] KIND_TRUNC   = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_TARGET_ID = 2'd0;
  localparam logic [1:0] REG_TAG_MASK  = 2'd1;
  localparam logic [1:0] REG_TAG_COUNT = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] RST_TARGET_ID = 8'hBD;
  localparam logic [7:0] RST_TAG_MASK  = 8'h80;
  localparam logic [3:0] RST_TAG_COUNT = 4'd4;

  typedef struct packed {
    logic [7:0] target_id;
    logic [7:0] tag_mask;
    logic [3:0] tag_count;
  } cfg_t;

  // One parsed input byte worth of results: an optional payload byte followed
  // by an optional terminating status.
  typedef struct packed {
    logic       has_payload;
    logic [7:0] data;
    logic       has_term;
    logic [2:0] term_kind;
  } event_t;

endpackage

// ===== rtl/program_stream_audio_demux_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// program_stream_audio_demux_core: program stream payload extractor
// Parses an MPEG-2 program stream byte by byte and forwards the payload of
// one selected PES stream, followed by a status beat when the stream ends.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | tdata          | tuser    | tlast
//  ---------+-----------+----------------+----------+------------------------
//  s_*      | in        | [7:0] in_byte  | -        | end_of_input
//  m_*      | out       | [7:0] out_byte | [2:0]kind| last result of a byte
//  cfg_*    | in        | index 0 target stream id, 1 tag mask, 2 tag count
//
// One input beat is taken per cycle. A byte yields at most one beat, except
// the final byte of a truncated stream, which may yield a payload beat and a
// status beat; the output register sends one beat per cycle, so the sustained
// rate is one byte per cycle. The parser and the output stage are parted by a
// small event queue, so a stalled output only holds the input once the queue
// is full, and the parser keeps running while earlier results wait.
// Reset (rst, synchronous) returns the parser to waiting for the opening pack
// start code, empties the queue and restores the register defaults.
//
module program_stream_audio_demux_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  // Input stream.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] in_byte
  input  logic       s_tlast,    // end_of_input
  // Output stream.
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] out_byte
  output logic [2:0] m_tuser,    // [2:0] kind
  output logic       m_tlast,    // last
  // Configuration writes.
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  psad_pkg::cfg_t   cfg;
  logic             push;
  psad_pkg::event_t push_evt;
  logic             queue_full;
  logic             pop;
  logic             evt_valid;
  psad_pkg::event_t head;

  // Registers are read by the parser on every byte, so a write takes effect
  // from the next accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_id <= psad_pkg::RST_TARGET_ID;
      cfg.tag_mask  <= psad_pkg::RST_TAG_MASK;
      cfg.tag_count <= psad_pkg::RST_TAG_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        psad_pkg::REG_TARGET_ID: cfg.target_id <= cfg_data;
        psad_pkg::REG_TAG_MASK:  cfg.tag_mask  <= cfg_data;
        psad_pkg::REG_TAG_COUNT: cfg.tag_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Front: classifies every byte and emits an event when it yields results.
  psad_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_eoi     (s_tlast),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_evt   (push_evt)
  );

  // Queue: decouples the parser from output back-pressure.
  psad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_evt  (push_evt),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (evt_valid),
    .head      (head)
  );

  // Back: splits events into beats and drives the output register.
  psad_back u_back (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt       (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_kind  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

// ===== rtl/psad_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psad_front: program stream parser
// Walks pack headers, stuffing, start codes and PES packets one byte per
// cycle while the queue has room; one event for each byte yielding a result.
// ----------------------------------------------------------------------------
module psad_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_eoi,
  input  psad_pkg::cfg_t     cfg,
  input  logic               queue_full,
  output logic               push,
  output psad_pkg::event_t   push_evt
);

  localparam logic [2:0] PH_SYNC       = 3'd0;
  localparam logic [2:0] PH_PACK       = 3'd1;
  localparam logic [2:0] PH_STUFF      = 3'd2;
  localparam logic [2:0] PH_CODE_FIRST = 3'd3;
  localparam logic [2:0] PH_CODE       = 3'd4;
  localparam logic [2:0] PH_UNIT       = 3'd5;

  localparam logic [7:0] SC_PACK   = 8'hBA;
  localparam logic [7:0] SC_SYSTEM = 8'hBB;
  localparam logic [7:0] SC_END    = 8'hB9;

  logic [2:0]  phase, phase_next;
  logic [16:0] idx, idx_next;
  logic [15:0] unit_len, unit_len_next;
  logic [8:0]  hdr_bytes, hdr_bytes_next;
  logic [2:0]  stuff_left, stuff_left_next;
  logic        fwd, fwd_next;
  logic        finished, finished_next;

  logic              accept;
  psad_pkg::event_t  evt;
  logic [15:0]       unit_len_now;
  logic [8:0]        tag_pos;
  logic [2:0]        stuff_dec;
  logic              sync_bad;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_next      = phase;
    idx_next        = idx;
    unit_len_next   = unit_len;
    hdr_bytes_next  = hdr_bytes;
    stuff_left_next = stuff_left;
    fwd_next        = fwd;
    finished_next   = finished;
    evt             = '0;
    unit_len_now    = unit_len;
    tag_pos         = hdr_bytes - 9'(cfg.tag_count);
    stuff_dec       = stuff_left - 3'd1;
    // The two bytes before the third are already known to be zero, so the
    // third start code byte only has to equal one.
    sync_bad = ((idx < 17'd2) && (in_byte != 8'h00)) ||
               ((idx == 17'd2) && (in_byte != 8'h01));

    if (!finished) begin
      case (phase)
        PH_SYNC: begin
          if (sync_bad || ((idx >= 17'd3) && (in_byte != SC_PACK))) begin
            evt.has_term  = 1'b1;
            evt.term_kind = psad_pkg::KIND_NOT_PS;
            finished_next = 1'b1;
          end else if (idx >= 17'd3) begin
            phase_next = PH_PACK;
            idx_next   = 17'd4;
          end else begin
            idx_next = idx + 17'd1;
          end
        end
        PH_PACK: begin
          if (idx >= 17'd13) begin
            stuff_left_next = in_byte[2:0];
            phase_next      = (in_byte[2:0] != 3'd0) ? PH_STUFF : PH_CODE_FIRST;
            idx_next        = 17'd0;
          end else begin
            idx_next = idx + 17'd1;
          end
        end
        PH_STUFF: begin
          stuff_left_next = stuff_dec;
          if (stuff_dec == 3'd0) begin
            phase_next = PH_CODE_FIRST;
            idx_next   = 17'd0;
          end
        end
        PH_CODE_FIRST, PH_CODE: begin
          if (sync_bad) begin
            evt.has_term  = 1'b1;
            evt.term_kind = psad_pkg::KIND_SYNC;
            finished_next = 1'b1;
          end else if (idx < 17'd3) begin
            idx_next = idx + 17'd1;
          end else if (in_byte == SC_PACK) begin
            phase_next = PH_PACK;
            idx_next   = 17'd4;
          end else if (in_byte == SC_END) begin
            evt.has_term  = 1'b1;
            evt.term_kind = psad_pkg::KIND_END;
            finished_next = 1'b1;
          end else begin
            // A system header is only recognized right after a pack header.
            fwd_next = !((phase == PH_CODE_FIRST) && (in_byte == SC_SYSTEM)) &&
                       (in_byte == cfg.target_id);
            unit_len_next  = 16'd0;
            hdr_bytes_next = 9'd0;
            phase_next     = PH_UNIT;
            idx_next       = 17'd4;
          end
        end
        PH_UNIT: begin
          if (idx == 17'd4) begin
            unit_len_now = {in_byte, 8'h00};
          end else if (idx == 17'd5) begin
            unit_len_now = unit_len | {8'h00, in_byte};
          end
          unit_len_next = unit_len_now;
          if (fwd) begin
            if (idx == 17'd8) begin
              hdr_bytes_next = 9'(in_byte) + 9'd9 + 9'(cfg.tag_count);
            end else if (idx >= 17'd9) begin
              if ((cfg.tag_count != 4'd0) && (hdr_bytes >= 9'(cfg.tag_count)) &&
                  (idx == 17'(tag_pos)) && ((in_byte & cfg.tag_mask) == 8'h00)) begin
                fwd_next = 1'b0;
              end else if (idx >= 17'(hdr_bytes)) begin
                evt.has_payload = 1'b1;
                evt.data        = in_byte;
              end
            end
          end
          if ((idx >= 17'd5) && (idx == (17'(unit_len_now) + 17'd5))) begin
            phase_next = PH_CODE;
            idx_next   = 17'd0;
            fwd_next   = 1'b0;
          end else begin
            idx_next = idx + 17'd1;
          end
        end
        default: begin
          phase_next = PH_SYNC;
        end
      endcase

      if (in_eoi && !finished_next) begin
        evt.has_term  = 1'b1;
        evt.term_kind = psad_pkg::KIND_TRUNC;
        finished_next = 1'b1;
      end
    end
  end

  assign push     = accept && (evt.has_payload || evt.has_term);
  assign push_evt = evt;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SYNC;
      idx        <= '0;
      unit_len   <= '0;
      hdr_bytes  <= '0;
      stuff_left <= '0;
      fwd        <= 1'b0;
      finished   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      idx        <= idx_next;
      unit_len   <= unit_len_next;
      hdr_bytes  <= hdr_bytes_next;
      stuff_left <= stuff_left_next;
      fwd        <= fwd_next;
      finished   <= finished_next;
    end
  end

endmodule

// ===== rtl/psad_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psad_queue: event queue between parser and output stage
// A small circular buffer of parser events with full and empty flags.
// ----------------------------------------------------------------------------
module psad_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  psad_pkg::event_t push_evt,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output psad_pkg::event_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  psad_pkg::event_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/psad_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psad_back: result serializer and output register
// Turns each event into one or two output beats and holds them until taken.
// ----------------------------------------------------------------------------
module psad_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             evt_valid,
  input  psad_pkg::event_t evt,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_kind,
  output logic             out_last
);

  logic       load;
  logic       pend;
  logic [2:0] pend_kind;

  assign load = !out_valid || out_ready;
  assign pop  = load && !pend && evt_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (evt_valid) begin
        out_valid <= 1'b1;
        pend      <= evt.has_payload && evt.has_term;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        out_byte <= 8'h00;
        out_kind <= pend_kind;
        out_last <= 1'b1;
      end else if (evt_valid) begin
        pend_kind <= evt.term_kind;
        if (evt.has_payload) begin
          out_byte <= evt.data;
          out_kind <= psad_pkg::KIND_PAYLOAD;
          out_last <= !evt.has_term;
        end else begin
          out_byte <= 8'h00;
          out_kind <= evt.term_kind;
          out_last <= 1'b1;
        end
      end
    end
  end

endmodule
